// ===== src/cwms_pkg.sv =====
`default_nettype none
package cwms_pkg;

  localparam logic [2:0] REG_CLIP_ENABLE = 3'd0;
  localparam logic [2:0] REG_CLIP_HIGH   = 3'd1;
  localparam logic [2:0] REG_CLIP_LOW    = 3'd2;
  localparam logic [2:0] REG_BAD_VALUE   = 3'd3;
  localparam logic [2:0] REG_COL_FIRST   = 3'd4;
  localparam logic [2:0] REG_COL_FINAL   = 3'd5;
  localparam logic [2:0] REG_ROW_FIRST   = 3'd6;
  localparam logic [2:0] REG_ROW_FINAL   = 3'd7;

  localparam int SUM_W = 64;

  // controller -> datapath
  typedef struct packed {
    logic acc_load;    // latch a pixel beat and update accumulators
    logic div_start;   // begin sum / count
    logic sq_start;    // begin mean^2 * count product
    logic div2_start;  // begin variance / count
    logic sqrt_start;  // begin square root
    logic clear;       // clear accumulators
  } cwms_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic unit_done;
  } cwms_sts_t;

endpackage
`default_nettype wire

// ===== src/clipped_window_mean_stddev.sv =====
`default_nettype none
// Clipped window mean / standard deviation over a raster pixel stream.
// Each input beat yields one pixel write-back beat (kind 0); a beat with
// frame_end also yields a statistics beat (kind 1: mean, std_dev, count),
// then clears the accumulators. Ordinary pixels run at one beat per cycle
// while the output is taken. After frame end, a shared bit-serial unit
// runs divide (64 steps), product (64), divide (64) and square root (32)
// in turn; the statistics beat is valid once the square root is done,
// and the input stays stalled until the statistics beat is taken.
// Config via APB at 4*index.
module clipped_window_mean_stddev #(
  parameter int PIXEL_WIDTH = 24,
  parameter int COORD_WIDTH = 12,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [4:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic signed [PIXEL_WIDTH-1:0] pixel_i,
  input  wire logic [COORD_WIDTH-1:0] col_i,
  input  wire logic [COORD_WIDTH-1:0] row_i,
  input  wire logic                   frame_end_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic                        kind_o,
  output logic signed [PIXEL_WIDTH-1:0] pixel_out_o,
  output logic signed [PIXEL_WIDTH-1:0] mean_o,
  output logic [PIXEL_WIDTH-1:0]      std_dev_o,
  output logic [COUNT_WIDTH-1:0]      count_o,
  output logic                        last_o
);
  import cwms_pkg::*;

  logic clip_en_q;
  logic [PIXEL_WIDTH-1:0] clip_high_q, clip_low_q, bad_q;
  logic [COORD_WIDTH-1:0] cf_q, cl_q, rf_q, rl_q;
  logic wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr  = psel && penable && pwrite;
  assign idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_en_q   <= 1'b0;
      clip_high_q <= {1'b0, {(PIXEL_WIDTH-1){1'b1}}};
      clip_low_q  <= {1'b1, {(PIXEL_WIDTH-1){1'b0}}};
      bad_q       <= {1'b1, {(PIXEL_WIDTH-1){1'b0}}};
      cf_q <= '0;
      cl_q <= '1;
      rf_q <= '0;
      rl_q <= '1;
    end else if (wr) begin
      case (idx)
        REG_CLIP_ENABLE: clip_en_q   <= pwdata[0];
        REG_CLIP_HIGH:   clip_high_q <= pwdata[PIXEL_WIDTH-1:0];
        REG_CLIP_LOW:    clip_low_q  <= pwdata[PIXEL_WIDTH-1:0];
        REG_BAD_VALUE:   bad_q       <= pwdata[PIXEL_WIDTH-1:0];
        REG_COL_FIRST:   cf_q <= pwdata[COORD_WIDTH-1:0];
        REG_COL_FINAL:   cl_q <= pwdata[COORD_WIDTH-1:0];
        REG_ROW_FIRST:   rf_q <= pwdata[COORD_WIDTH-1:0];
        REG_ROW_FINAL:   rl_q <= pwdata[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CLIP_ENABLE: prdata = {31'd0, clip_en_q};
      REG_CLIP_HIGH:   prdata = 32'(clip_high_q);
      REG_CLIP_LOW:    prdata = 32'(clip_low_q);
      REG_BAD_VALUE:   prdata = 32'(bad_q);
      REG_COL_FIRST:   prdata = 32'(cf_q);
      REG_COL_FINAL:   prdata = 32'(cl_q);
      REG_ROW_FIRST:   prdata = 32'(rf_q);
      REG_ROW_FINAL:   prdata = 32'(rl_q);
      default:         prdata = '0;
    endcase
  end

  cwms_cmd_t cmd;
  cwms_sts_t sts;

  cwms_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .frame_end_i,
    .out_valid_o, .out_stall_i, .out_kind_o(kind_o), .out_last_o(last_o),
    .cmd_o(cmd), .sts_i(sts)
  );

  cwms_dp #(.PIXEL_WIDTH(PIXEL_WIDTH), .COORD_WIDTH(COORD_WIDTH),
            .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .clip_enable_i(clip_en_q), .clip_high_i(clip_high_q), .clip_low_i(clip_low_q),
    .bad_value_i(bad_q), .col_first_i(cf_q), .col_final_i(cl_q),
    .row_first_i(rf_q), .row_final_i(rl_q),
    .pixel_i, .col_i, .row_i,
    .pixel_out_o, .mean_o, .std_dev_o, .count_o
  );
endmodule
`default_nettype wire

// ===== src/cwms_ctrl.sv =====
`default_nettype none
module cwms_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              frame_end_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   out_kind_o,
  output logic                   out_last_o,
  output cwms_pkg::cwms_cmd_t    cmd_o,
  input  wire cwms_pkg::cwms_sts_t sts_i
);
  import cwms_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PIX  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SQ   = 3'd3;
  localparam logic [2:0] S_DIV2 = 3'd4;
  localparam logic [2:0] S_SQRT = 3'd5;
  localparam logic [2:0] S_STAT = 3'd6;

  logic [2:0] state_q, state_d;
  logic       fend_q, fend_d;
  logic       accept, out_take;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_take = out_valid_o && !out_stall_i;

  // Pixel result may sit in the output register while the next beat enters.
  assign in_stall_o  = !(state_q == S_IDLE || (state_q == S_PIX && !fend_q && out_take));
  assign out_valid_o = (state_q == S_PIX) || (state_q == S_STAT);
  assign out_kind_o  = (state_q == S_STAT);
  assign out_last_o  = (state_q == S_STAT) || !fend_q;

  always_comb begin
    state_d = state_q;
    fend_d  = fend_q;
    cmd_o   = '0;
    cmd_o.acc_load = accept;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_PIX;
          fend_d  = frame_end_i;
        end
      end
      S_PIX: begin
        if (out_take) begin
          if (fend_q) begin
            state_d = S_DIV;
            cmd_o.div_start = 1'b1;
          end else if (accept) begin
            fend_d = frame_end_i;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_DIV: begin
        if (sts_i.unit_done) begin
          state_d = S_SQ;
          cmd_o.sq_start = 1'b1;
        end
      end
      S_SQ: begin
        if (sts_i.unit_done) begin
          state_d = S_DIV2;
          cmd_o.div2_start = 1'b1;
        end
      end
      S_DIV2: begin
        if (sts_i.unit_done) begin
          state_d = S_SQRT;
          cmd_o.sqrt_start = 1'b1;
        end
      end
      S_SQRT: begin
        if (sts_i.unit_done) state_d = S_STAT;
      end
      S_STAT: begin
        if (out_take) begin
          state_d = S_IDLE;
          cmd_o.clear = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fend_q  <= fend_d;
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV || state_q == S_SQRT || state_q == S_STAT) |-> in_stall_o)
    else $error("beat accepted during statistics");
  a_stat_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_kind_o) |-> out_last_o)
    else $error("statistics result without last");
  a_stat_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PIX && fend_q && out_take) |=> state_q == S_DIV)
    else $error("frame end not followed by statistics");
`endif
endmodule
`default_nettype wire

// ===== src/cwms_dp.sv =====
`default_nettype none
module cwms_dp #(
  parameter int PIXEL_WIDTH = 24,
  parameter int COORD_WIDTH = 12,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cwms_pkg::cwms_cmd_t      cmd_i,
  output cwms_pkg::cwms_sts_t           sts_o,
  input  wire logic                     clip_enable_i,
  input  wire logic signed [PIXEL_WIDTH-1:0] clip_high_i,
  input  wire logic signed [PIXEL_WIDTH-1:0] clip_low_i,
  input  wire logic signed [PIXEL_WIDTH-1:0] bad_value_i,
  input  wire logic [COORD_WIDTH-1:0]   col_first_i,
  input  wire logic [COORD_WIDTH-1:0]   col_final_i,
  input  wire logic [COORD_WIDTH-1:0]   row_first_i,
  input  wire logic [COORD_WIDTH-1:0]   row_final_i,
  input  wire logic signed [PIXEL_WIDTH-1:0] pixel_i,
  input  wire logic [COORD_WIDTH-1:0]   col_i,
  input  wire logic [COORD_WIDTH-1:0]   row_i,
  output logic signed [PIXEL_WIDTH-1:0] pixel_out_o,
  output logic signed [PIXEL_WIDTH-1:0] mean_o,
  output logic [PIXEL_WIDTH-1:0]        std_dev_o,
  output logic [COUNT_WIDTH-1:0]        count_o
);
  import cwms_pkg::*;

  localparam int W = SUM_W;
  localparam int CNT_MAX = (1 << COUNT_WIDTH) - 1;
  localparam int DCW = $clog2(W + 1);

  logic signed [W-1:0] sum_q;
  logic [W-1:0] sumsq_q;
  logic [COUNT_WIDTH-1:0] cnt_q;
  logic [PIXEL_WIDTH-1:0] pout_q;

  logic inwin, ok;
  logic [PIXEL_WIDTH-1:0] mag;
  logic signed [W-1:0] p_ext;

  assign inwin = col_i >= col_first_i && col_i <= col_final_i &&
                 row_i >= row_first_i && row_i <= row_final_i;
  assign ok = (pixel_i != bad_value_i) &&
              (!clip_enable_i || (pixel_i < clip_high_i && pixel_i > clip_low_i));
  assign p_ext = W'(pixel_i);
  assign mag = pixel_i[PIXEL_WIDTH-1] ? PIXEL_WIDTH'(-pixel_i) : PIXEL_WIDTH'(pixel_i);

  // Square of one pixel magnitude, registered before accumulation.
  logic [2*PIXEL_WIDTH-1:0] sq_q;
  logic                     sq_add_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      sumsq_q  <= '0;
      cnt_q    <= '0;
      sq_add_q <= 1'b0;
    end else begin
      sq_add_q <= 1'b0;
      if (sq_add_q) sumsq_q <= sumsq_q + W'(sq_q);
      if (cmd_i.clear) begin
        sum_q   <= '0;
        sumsq_q <= '0;
        cnt_q   <= '0;
      end else if (cmd_i.acc_load && inwin && ok && cnt_q != COUNT_WIDTH'(CNT_MAX)) begin
        sum_q    <= sum_q + p_ext;
        cnt_q    <= cnt_q + 1'b1;
        sq_add_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= mag * mag;
    if (cmd_i.acc_load) pout_q <= (inwin && !ok) ? bad_value_i : pixel_i;
  end

  // Shared restoring divider (W-bit numerator / count), one bit per cycle.
  // Also used bit-serially for the product and the square root.
  logic [W-1:0] quo_q, rem_q, num_q, acc_q;
  logic [DCW-1:0] step_q, step_m1;
  logic [1:0] op_q;
  logic busy_q, done_q;
  logic neg_q;
  logic mmag_done_sel_q;
  logic [W-1:0] mmag_q, msq_q, var_q, root_q;
  logic [W-1:0] smag;
  logic [W:0] rem_sh, trial;
  logic [W-1:0] bitv, tsum;
  logic [PIXEL_WIDTH+COUNT_WIDTH-1:0] mc_prod;

  localparam logic [1:0] OP_DIV = 2'd0;
  localparam logic [1:0] OP_MUL = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  assign smag    = sum_q[W-1] ? -sum_q : sum_q;
  assign rem_sh  = {rem_q, num_q[W-1]};
  assign trial   = rem_sh - {{(W-COUNT_WIDTH+1){1'b0}}, cnt_q};
  assign step_m1 = step_q - 1'b1;
  assign bitv    = W'(1) << {step_m1[DCW-2:0], 1'b0};
  assign tsum    = quo_q + bitv;
  // mean magnitude never exceeds one pixel magnitude
  assign mc_prod = mmag_q[PIXEL_WIDTH-1:0] * cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.div_start || cmd_i.sq_start || cmd_i.div2_start || cmd_i.sqrt_start)
        busy_q <= 1'b1;
      else if (busy_q && step_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start || cmd_i.div2_start) begin
      op_q   <= OP_DIV;
      num_q  <= cmd_i.div_start ? smag :
                ((sumsq_q > msq_q) ? sumsq_q - msq_q : '0);
      rem_q  <= '0;
      quo_q  <= '0;
      step_q <= DCW'(W);
      if (cmd_i.div_start) neg_q <= sum_q[W-1];
    end else if (cmd_i.sq_start) begin
      // msq = (count * mmag) * mmag: small product first, then shift-add over mmag bits
      op_q   <= OP_MUL;
      num_q  <= mmag_q;
      acc_q  <= '0;
      quo_q  <= W'(mc_prod);
      rem_q  <= '0;
      step_q <= DCW'(W);
    end else if (cmd_i.sqrt_start) begin
      op_q   <= OP_SQRT;
      num_q  <= var_q;
      quo_q  <= '0;
      step_q <= DCW'(W/2);
    end else if (busy_q && step_q != '0) begin
      step_q <= step_q - 1'b1;
      case (op_q)
        OP_DIV: begin
          num_q <= {num_q[W-2:0], 1'b0};
          if (!trial[W]) begin
            rem_q <= trial[W-1:0];
            quo_q <= {quo_q[W-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh[W-1:0];
            quo_q <= {quo_q[W-2:0], 1'b0};
          end
        end
        OP_MUL: begin
          // acc += (num bit) ? quo << k ; shift quo left, num right
          if (num_q[0]) acc_q <= acc_q + quo_q;
          num_q <= num_q >> 1;
          quo_q <= quo_q << 1;
        end
        OP_SQRT: begin
          // bitv = 4^(step-1); quo holds res
          if (num_q >= tsum) begin
            num_q <= num_q - tsum;
            quo_q <= (quo_q >> 1) + bitv;
          end else begin
            quo_q <= quo_q >> 1;
          end
        end
        default: ;
      endcase
    end
    // results land as the unit finishes, ready for the next start
    if (busy_q && step_q == '0) begin
      case (op_q)
        OP_DIV:  if (mmag_done_sel_q) var_q <= quo_q; else mmag_q <= quo_q;
        OP_MUL:  msq_q <= acc_q;
        OP_SQRT: root_q <= quo_q;
        default: ;
      endcase
    end
  end

  // Second divide targets the variance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mmag_done_sel_q <= 1'b0;
    else if (cmd_i.div_start) mmag_done_sel_q <= 1'b0;
    else if (cmd_i.div2_start) mmag_done_sel_q <= 1'b1;
  end

  assign sts_o.unit_done = done_q;

  logic stat_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) stat_q <= 1'b0;
    else if (cmd_i.div_start) stat_q <= 1'b1;
    else if (cmd_i.acc_load || cmd_i.clear) stat_q <= 1'b0;
  end

  logic [W-1:0] mean_s;
  assign mean_s = neg_q ? -mmag_q : mmag_q;
  assign pixel_out_o = stat_q ? '0 : pout_q;
  assign mean_o    = (stat_q && cnt_q != '0) ? PIXEL_WIDTH'(mean_s) : '0;
  assign std_dev_o = (stat_q && cnt_q != '0) ? PIXEL_WIDTH'(root_q) : '0;
  assign count_o   = stat_q ? cnt_q : '0;

`ifndef ASSERT_OFF
  a_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == COUNT_WIDTH'(CNT_MAX) && !cmd_i.clear) |=> cnt_q == COUNT_WIDTH'(CNT_MAX))
    else $error("count left saturation");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> cnt_q == '0)
    else $error("count not cleared");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("done longer than one cycle");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/tb_clipped_window_mean_stddev.sv =====
`default_nettype none
module tb_clipped_window_mean_stddev;
  import cwms_pkg::*;

  localparam int PW = 24;
  localparam int CW = 12;
  localparam int NW = 16;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 300; // extra idle margin after all expected results have been delivered

  typedef struct {
    logic signed [PW-1:0] pixel;
    logic [CW-1:0]        col;
    logic [CW-1:0]        row;
    logic                 fend;
  } pix_beat_t;

  typedef struct {
    logic                 kind;
    logic signed [PW-1:0] pixel_out;
    logic signed [PW-1:0] mean;
    logic [PW-1:0]        std_dev;
    logic [NW-1:0]        count;
    logic                 last;
  } res_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  wire logic [31:0] prdata;
  wire logic pready;
  logic in_valid_i = 1'b0;
  wire logic in_stall_o;
  logic signed [PW-1:0] pixel_i = '0;
  logic [CW-1:0] col_i = '0, row_i = '0;
  logic frame_end_i = 1'b0;
  wire logic out_valid_o;
  logic out_stall_i = 1'b0;
  wire logic kind_o;
  wire logic signed [PW-1:0] pixel_out_o, mean_o;
  wire logic [PW-1:0] std_dev_o;
  wire logic [NW-1:0] count_o;
  wire logic last_o;

  clipped_window_mean_stddev dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the register file
  logic                 m_clip_en;
  logic signed [PW-1:0] m_clip_hi, m_clip_lo, m_bad;
  logic [CW-1:0]        m_c0, m_c1, m_r0, m_r1;
  // shadow accumulators
  logic signed [63:0]   m_sum;
  logic [63:0]          m_sumsq;
  logic [NW-1:0]        m_cnt;

  pix_beat_t pend_q[$];
  res_beat_t expected_q[$];
  int errors = 0;
  int n_pixels = 0, n_frames = 0, n_results = 0;
  bit burst = 0;     // when set, neither side idles
  bit have = 0;
  pix_beat_t cur;
  int in_gap = 0, out_gap = 0;
  int cycles = 0;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v = v - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // Update the shadow accumulators for one pixel and queue its results.
  task automatic predict_stats(pix_beat_t b);
    res_beat_t r;
    logic ok, neg;
    logic signed [63:0] p;
    logic [63:0] mag, smag, mmag, msq, sd, n;
    p = b.pixel;
    r = '{kind: 1'b0, pixel_out: b.pixel, mean: '0, std_dev: '0, count: '0, last: !b.fend};
    if (b.col >= m_c0 && b.col <= m_c1 && b.row >= m_r0 && b.row <= m_r1) begin
      ok = (b.pixel != m_bad);
      if (ok && m_clip_en) ok = (b.pixel < m_clip_hi) && (b.pixel > m_clip_lo);
      if (!ok) begin
        r.pixel_out = m_bad;
      end else if (m_cnt != {NW{1'b1}}) begin
        // saturated count freezes all three accumulators
        mag = (p < 0) ? -p : p;
        m_sum = m_sum + p;
        m_sumsq = m_sumsq + mag * mag;
        m_cnt = m_cnt + 1'b1;
      end
    end
    expected_q.push_back(r);
    if (b.fend) begin
      r = '{kind: 1'b1, pixel_out: '0, mean: '0, std_dev: '0, count: '0, last: 1'b1};
      if (m_cnt != 0) begin
        n = m_cnt;
        neg = m_sum[63];
        smag = neg ? -m_sum : m_sum;
        mmag = smag / n;
        msq = n * (mmag * mmag);
        sd = (m_sumsq > msq) ? int_sqrt((m_sumsq - msq) / n) : 64'd0;
        r.mean = neg ? -mmag : mmag;
        r.std_dev = sd[PW-1:0];
        r.count = m_cnt;
      end
      expected_q.push_back(r);
      m_sum = 0;
      m_sumsq = 0;
      m_cnt = 0;
      n_frames++;
    end
  endtask

  function automatic int draw_gap();
    if (burst) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  // driver: one beat in flight, gap drawn after each accepted beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_stats(cur);
        n_pixels++;
        have = 0;
        in_gap = draw_gap();
      end
      if (!have) begin
        if (in_gap > 0) in_gap--;
        else if (pend_q.size() > 0) begin
          cur = pend_q.pop_front();
          have = 1;
        end
      end
      in_valid_i <= have;
      pixel_i <= cur.pixel;
      col_i <= cur.col;
      row_i <= cur.row;
      frame_end_i <= cur.fend;
    end
  end

  // monitor: compare each accepted result beat with the oldest expectation
  always @(posedge clk_i) begin
    res_beat_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat kind=%0d pixel_out=%0d", $time, kind_o,
                   pixel_out_o);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (kind_o !== e.kind) begin
            $display("%0t: kind exp %0d got %0d", $time, e.kind, kind_o); errors++;
          end
          if (pixel_out_o !== e.pixel_out) begin
            $display("%0t: pixel_out exp %0d got %0d", $time, e.pixel_out, pixel_out_o);
            errors++;
          end
          if (mean_o !== e.mean) begin
            $display("%0t: mean exp %0d got %0d", $time, e.mean, mean_o); errors++;
          end
          if (std_dev_o !== e.std_dev) begin
            $display("%0t: std_dev exp %0d got %0d", $time, e.std_dev, std_dev_o); errors++;
          end
          if (count_o !== e.count) begin
            $display("%0t: count exp %0d got %0d", $time, e.count, count_o); errors++;
          end
          if (last_o !== e.last) begin
            $display("%0t: last exp %0d got %0d", $time, e.last, last_o); errors++;
          end
        end
        out_gap = draw_gap();
      end else if (out_gap > 0) begin
        out_gap--;
      end
      out_stall_i <= (out_gap > 0);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // APB write: setup cycle, then access cycle; register lands at the access edge
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_CLIP_ENABLE: m_clip_en = val[0];
      REG_CLIP_HIGH:   m_clip_hi = val[PW-1:0];
      REG_CLIP_LOW:    m_clip_lo = val[PW-1:0];
      REG_BAD_VALUE:   m_bad = val[PW-1:0];
      REG_COL_FIRST:   m_c0 = val[CW-1:0];
      REG_COL_FINAL:   m_c1 = val[CW-1:0];
      REG_ROW_FIRST:   m_r0 = val[CW-1:0];
      REG_ROW_FINAL:   m_r1 = val[CW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic en, int hi, int lo, int bad, int c0, int c1, int r0, int r1);
    reg_write(REG_CLIP_ENABLE, en);
    reg_write(REG_CLIP_HIGH, hi);
    reg_write(REG_CLIP_LOW, lo);
    reg_write(REG_BAD_VALUE, bad);
    reg_write(REG_COL_FIRST, c0);
    reg_write(REG_COL_FINAL, c1);
    reg_write(REG_ROW_FIRST, r0);
    reg_write(REG_ROW_FINAL, r1);
  endtask

  task automatic push_px(int px, int c, int r, bit fe);
    pix_beat_t b;
    b.pixel = px; b.col = c; b.row = r; b.fend = fe;
    pend_q.push_back(b);
  endtask

  // sender holds off until the block has delivered everything
  task automatic wait_idle();
    while (pend_q.size() != 0 || have || expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic int rand_px();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? 32'sh7fffff : -32'sh800000;
      1: return m_bad;
      2: return m_clip_hi + $signed($urandom_range(0, 2)) - 1;
      3: return m_clip_lo + $signed($urandom_range(0, 2)) - 1;
      4, 5: return $signed({{8{1'b0}}, 24'd0}) + $signed($urandom_range(0, 4000)) - 2000;
      default: return $signed({{8{1'b0}}, $urandom()}) << 8 >>> 8;
    endcase
  endfunction

  function automatic int rand_coord(int hi);
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 4095);
    return $urandom_range(0, hi);
  endfunction

  initial begin
    int lo, hi, w, h, sent;
    m_clip_en = 0; m_clip_hi = 24'h7fffff; m_clip_lo = 24'h800000; m_bad = 24'h800000;
    m_c0 = 0; m_c1 = 12'hfff; m_r0 = 0; m_r1 = 12'hfff;
    m_sum = 0; m_sumsq = 0; m_cnt = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, field extremes, bad value marker
    push_px(32'sh7fffff, 0, 0, 0);
    push_px(-32'sh800000, 4095, 4095, 0);   // equals bad value at reset
    push_px(0, 4095, 0, 0);
    push_px(-1, 0, 4095, 0);
    push_px(32'sh7fffff, 2048, 2048, 1);
    push_px(-32'sh800000, 1, 1, 1);          // frame with nothing accepted
    wait_idle();

    // directed: clipping, window edges, pixels at the limits
    set_all(1, 100, -100, 0, 2, 5, 1, 3);
    push_px(100, 2, 1, 0);   // at high limit
    push_px(-100, 5, 3, 0);  // at low limit
    push_px(99, 2, 3, 0);
    push_px(-99, 5, 1, 0);
    push_px(0, 3, 2, 0);     // bad value
    push_px(50, 1, 2, 0);    // left of window
    push_px(50, 6, 2, 0);
    push_px(50, 3, 0, 0);
    push_px(50, 3, 4, 1);    // frame end outside window
    wait_idle();

    // directed: empty window, and extreme limits with clipping on
    set_all(1, -32'sh800000, 32'sh7fffff, 32'sh7fffff, 10, 5, 0, 4095);
    push_px(7, 7, 7, 0);
    push_px(32'sh7fffff, 10, 0, 1);
    wait_idle();

    // random phases: raster frames with random content, plus noise beats
    sent = 0;
    for (int ph = 0; ph < 12; ph++) begin
      lo = $signed($urandom_range(0, 4000)) - 3000;
      hi = lo + $signed($urandom_range(0, 4000));
      if (ph == 3) begin lo = -32'sh800000; hi = 32'sh7fffff; end
      set_all($urandom_range(0, 1), hi, lo,
              $urandom_range(0, 1) ? -32'sh800000 : $signed($urandom_range(0, 200)) - 100,
              $urandom_range(0, 4), ph == 5 ? 4095 : $urandom_range(2, 9),
              $urandom_range(0, 4), ph == 6 ? 4095 : $urandom_range(2, 9));
      burst = (ph == 8);
      for (int f = 0; f < 18; f++) begin
        if ($urandom_range(0, 5) == 0) begin
          // noise: scattered coordinates, random frame end
          for (int k = 0; k < 6; k++)
            push_px(rand_px(), rand_coord(4095), rand_coord(4095), $urandom_range(0, 7) == 0);
          sent += 6;
        end else begin
          w = $urandom_range(1, 10);
          h = $urandom_range(1, 6);
          for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
              push_px(rand_px(), x, y, (x == w - 1) && (y == h - 1));
          sent += w * h;
        end
      end
      wait_idle();
      if (sent > 1600) break;
    end
    burst = 0;

    $display("Covered %0d pixel beats in %0d frames, %0d result beats checked,",
             n_pixels, n_frames, n_results);
    $display("with clipping, window edges, empty windows and empty frames exercised.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== clipped_window_mean_stddev.f =====
src/cwms_pkg.sv
src/cwms_ctrl.sv
src/cwms_dp.sv
src/clipped_window_mean_stddev.sv
tb/sv/tb_clipped_window_mean_stddev.sv
